// ----- rtl/core/brle_pkg.sv -----
// ----------------------------------------------------------------------------
// Bit run-length encoder package
// Shared widths, constants and the structures that travel between the
// run tracker, the token queue and the budget stage.
// ----------------------------------------------------------------------------
package brle_pkg;

    // Field widths.
    localparam int CNT_W = 8;
    localparam int POS_W = 16;

    // Longest run that one token can carry.
    localparam logic [CNT_W-1:0] RUN_CAP = 8'd255;

    // Compressed size of one token, sized for the budget compare.
    localparam logic [POS_W:0] TOKEN_BITS = 17'd9;

    // Reset value of the budget register.
    localparam logic [POS_W-1:0] BUDGET_RESET = 16'hFFFF;

    // Token queue between the run tracker and the budget stage.
    localparam int TQ_DEPTH = 4;
    localparam int TQ_PTR_W = 2;
    localparam int TQ_CNT_W = 3;

    // Result queue at the output.
    localparam int OQ_DEPTH = 2;
    localparam int OQ_PTR_W = 1;
    localparam int OQ_CNT_W = 2;

    // One run token as found by the run tracker.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             value;
        logic             last;
    } token_t;

    // Up to two tokens written into the token queue in one cycle.
    typedef struct packed {
        logic   a_valid;
        token_t a;
        logic   b_valid;
        token_t b;
    } tok_wr_t;

    // One result request as delivered at the output.
    typedef struct packed {
        logic [CNT_W-1:0] run_length;
        logic             run_bit;
        logic             token_last;
        logic             overflow;
        logic [POS_W-1:0] total_bits;
    } result_t;

endpackage

// ----- rtl/core/brle_front.sv -----
// ----------------------------------------------------------------------------
// Run tracker
// Accepts one bit per cycle, follows the current run and classifies each
// bit into at most two tokens: a change or cap token, and a final token.
// ----------------------------------------------------------------------------
module brle_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            bit_value,
    input  logic            last_bit,
    input  logic            accept,
    output brle_pkg::tok_wr_t wr
);
    import brle_pkg::*;

    logic             run_value_reg;
    logic             run_value_next;
    logic [CNT_W-1:0] run_count_reg;
    logic [CNT_W-1:0] run_count_next;
    logic             first_reg;
    logic             first_next;

    // Run update and token classification for an accepted bit.
    always_comb
    begin
        logic             new_value;
        logic [CNT_W-1:0] new_count;
        new_value = run_value_reg;
        new_count = run_count_reg;
        wr        = '0;

        if (first_reg)
        begin
            new_value = bit_value;
            new_count = CNT_W'(1);
        end
        else if (bit_value == run_value_reg)
        begin
            if (run_count_reg == RUN_CAP)
            begin
                wr.a_valid = accept;
                wr.a       = '{count: run_count_reg, value: run_value_reg, last: 1'b0};
                new_count  = CNT_W'(1);
            end
            else
            begin
                new_count = run_count_reg + CNT_W'(1);
            end
        end
        else
        begin
            wr.a_valid = accept;
            wr.a       = '{count: run_count_reg, value: run_value_reg, last: 1'b0};
            new_value  = bit_value;
            new_count  = CNT_W'(1);
        end

        // The final bit always closes its run with a final token.
        wr.b_valid = accept & last_bit;
        wr.b       = '{count: new_count, value: new_value, last: 1'b1};

        run_value_next = run_value_reg;
        run_count_next = run_count_reg;
        first_next     = first_reg;
        if (accept)
        begin
            if (last_bit)
            begin
                run_value_next = 1'b0;
                run_count_next = '0;
                first_next     = 1'b1;
            end
            else
            begin
                run_value_next = new_value;
                run_count_next = new_count;
                first_next     = 1'b0;
            end
        end
    end

    // Run state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_value_reg <= 1'b0;
            run_count_reg <= '0;
            first_reg     <= 1'b1;
        end
        else
        begin
            run_value_reg <= run_value_next;
            run_count_reg <= run_count_next;
            first_reg     <= first_next;
        end
    end

endmodule

// ----- rtl/core/brle_tok_queue.sv -----
// ----------------------------------------------------------------------------
// Token queue
// Short queue between the run tracker and the budget stage. It takes up to
// two tokens per cycle and hands out one.
// ----------------------------------------------------------------------------
module brle_tok_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  brle_pkg::tok_wr_t wr,
    output logic              full,
    output logic              head_valid,
    output brle_pkg::token_t  head,
    input  logic              head_pop
);
    import brle_pkg::*;

    token_t              mem_reg [TQ_DEPTH];
    logic [TQ_PTR_W-1:0] wr_ptr_reg;
    logic [TQ_PTR_W-1:0] wr_ptr_next;
    logic [TQ_PTR_W-1:0] rd_ptr_reg;
    logic [TQ_PTR_W-1:0] rd_ptr_next;
    logic [TQ_CNT_W-1:0] count_reg;
    logic [TQ_CNT_W-1:0] count_next;
    logic [TQ_PTR_W-1:0] b_idx;
    logic [TQ_CNT_W-1:0] n_wr;

    // Room must remain for the two tokens one bit can make.
    assign full       = count_reg > TQ_CNT_W'(TQ_DEPTH - 2);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        b_idx       = wr.a_valid ? wr_ptr_reg + TQ_PTR_W'(1) : wr_ptr_reg;
        n_wr        = TQ_CNT_W'(wr.a_valid) + TQ_CNT_W'(wr.b_valid);
        wr_ptr_next = wr_ptr_reg + n_wr[TQ_PTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + TQ_PTR_W'(head_pop);
        count_next  = count_reg + n_wr - TQ_CNT_W'(head_pop);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Token storage.
    always_ff @(posedge clk)
    begin
        if (wr.a_valid)
        begin
            mem_reg[wr_ptr_reg] <= wr.a;
        end
        if (wr.b_valid)
        begin
            mem_reg[b_idx] <= wr.b;
        end
    end

endmodule

// ----- rtl/core/brle_back.sv -----
// ----------------------------------------------------------------------------
// Budget stage
// Charges each token against the bit budget, turns the first token that
// does not fit into an overflow result, drops the rest of an aborted stream
// and queues the results for the output.
// ----------------------------------------------------------------------------
module brle_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [brle_pkg::POS_W-1:0]   cfg_budget,
    input  logic                         tok_valid,
    input  brle_pkg::token_t             tok,
    output logic                         tok_pop,
    output logic                         res_empty,
    output brle_pkg::result_t            res,
    input  logic                         res_pop
);
    import brle_pkg::*;

    logic [POS_W-1:0]    budget_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic                aborted_reg;
    logic                aborted_next;
    result_t             oq_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] oq_wr_reg;
    logic [OQ_PTR_W-1:0] oq_rd_reg;
    logic [OQ_CNT_W-1:0] oq_count_reg;
    logic [OQ_CNT_W-1:0] oq_count_next;
    logic                oq_push;
    logic                oq_pop;
    result_t             new_res;
    logic [POS_W:0]      pos_sum;

    assign oq_pop    = res_pop & (oq_count_reg != '0);
    assign res_empty = oq_count_reg == '0;
    assign res       = oq_reg[oq_rd_reg];

    // Budget check and stream abort handling for the head token.
    always_comb
    begin
        pos_sum      = {1'b0, pos_reg} + TOKEN_BITS;
        tok_pop      = tok_valid & (aborted_reg | (oq_count_reg != OQ_CNT_W'(OQ_DEPTH)));
        oq_push      = 1'b0;
        new_res      = '0;
        pos_next     = pos_reg;
        aborted_next = aborted_reg;

        if (tok_pop)
        begin
            if (aborted_reg)
            begin
                // Rest of an aborted stream: drop until its final token.
                if (tok.last)
                begin
                    aborted_next = 1'b0;
                    pos_next     = '0;
                end
            end
            else if (pos_sum > {1'b0, budget_reg})
            begin
                oq_push            = 1'b1;
                new_res.token_last = 1'b1;
                new_res.overflow   = 1'b1;
                aborted_next       = ~tok.last;
                pos_next           = '0;
            end
            else
            begin
                oq_push            = 1'b1;
                new_res.run_length = tok.count;
                new_res.run_bit    = tok.value;
                new_res.token_last = tok.last;
                new_res.total_bits = tok.last ? pos_sum[POS_W-1:0] : '0;
                pos_next           = tok.last ? '0 : pos_sum[POS_W-1:0];
            end
        end

        oq_count_next = oq_count_reg + OQ_CNT_W'(oq_push) - OQ_CNT_W'(oq_pop);
    end

    // Control and budget registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg   <= BUDGET_RESET;
            pos_reg      <= '0;
            aborted_reg  <= 1'b0;
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                budget_reg <= cfg_budget;
            end
            pos_reg      <= pos_next;
            aborted_reg  <= aborted_next;
            oq_wr_reg    <= oq_wr_reg + OQ_PTR_W'(oq_push);
            oq_rd_reg    <= oq_rd_reg + OQ_PTR_W'(oq_pop);
            oq_count_reg <= oq_count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_reg[oq_wr_reg] <= new_res;
        end
    end

endmodule

// ----- rtl/core/bit_run_length_encoder.sv -----
// ----------------------------------------------------------------------------
// Bit run-length encoder
// Encodes a bit stream into 9-bit run tokens under a compressed bit budget.
// ----------------------------------------------------------------------------
// One input bit is taken per cycle, back to back, while the four-entry token
// queue has room for the two tokens a bit may produce; the budget stage
// retires one token per cycle into a two-entry result queue while it has
// room, so the sustained rate is one bit per cycle while results are popped.
// Results pass through both queues before they are visible. A final bit that
// closes a changed run yields two results, delivered in turn. The budget
// register resets to 65535 and is written through the cfg channel, which is
// always ready; write it only while no stream is in flight.
// ----------------------------------------------------------------------------
module bit_run_length_encoder
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       bit_value,
    input  logic                       last_bit,
    input  logic                       push,
    output logic                       full,
    output logic [brle_pkg::CNT_W-1:0] run_length,
    output logic                       run_bit,
    output logic                       token_last,
    output logic                       overflow,
    output logic [brle_pkg::POS_W-1:0] total_bits,
    output logic                       empty,
    input  logic                       pop,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [brle_pkg::POS_W-1:0] cfg_data
);
    import brle_pkg::*;

    tok_wr_t wr;
    token_t  head;
    logic    head_valid;
    logic    head_pop;
    logic    accept;
    result_t res;

    assign accept    = push & ~full;
    assign cfg_ready = 1'b1;

    // Run tracker.
    brle_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .bit_value (bit_value),
        .last_bit  (last_bit),
        .accept    (accept),
        .wr        (wr)
    );

    // Token queue between the two halves.
    brle_tok_queue u_tok_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .full       (full),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    // Budget stage and result queue.
    brle_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid & cfg_ready),
        .cfg_budget (cfg_data),
        .tok_valid  (head_valid),
        .tok        (head),
        .tok_pop    (head_pop),
        .res_empty  (empty),
        .res        (res),
        .res_pop    (pop)
    );

    assign run_length = res.run_length;
    assign run_bit    = res.run_bit;
    assign token_last = res.token_last;
    assign overflow   = res.overflow;
    assign total_bits = res.total_bits;

endmodule

// ----- sim/tb_bit_run_length_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit run-length encoder testbench
// Drives bit streams through the queue-style input, predicts every run token,
// overflow and final result in the testbench, and compares each popped result
// field by field. A short directed table is walked first. Random streams
// follow under several bit budgets and idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_bit_run_length_encoder;

    import brle_pkg::*;

    // Cycles allowed after the last expected result before the block is
    // treated as quiet.
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BITS   = 42;
    localparam int LONG_RUN     = 256;

    // Kinds of rows in the directed table.
    typedef enum logic [1:0] {ROW_BUDGET, ROW_PREDICTED, ROW_TYPED} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic             bv;
        logic             lb;
        logic [1:0]       n_typed;
        result_t          r0;
        result_t          r1;
        logic [POS_W-1:0] budget;
    } stim_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             bit_value;
    logic             last_bit;
    logic             push;
    logic             full;
    logic [CNT_W-1:0] run_length;
    logic             run_bit;
    logic             token_last;
    logic             overflow;
    logic [POS_W-1:0] total_bits;
    logic             empty;
    logic             pop;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [POS_W-1:0] cfg_data;

    // Expected results in delivery order.
    result_t   pending_tokens[$];
    stim_row_t directed_rows[$];

    // Encoder state as the testbench tracks it.
    logic      trk_bit;
    int        trk_count;
    int        out_bits;
    bit        fresh_stream;
    bit        stream_dropped;
    int        budget_limit;

    int        err_count;
    int        bits_sent;
    int        send_idle;
    int        recv_idle;

    bit_run_length_encoder dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .bit_value  (bit_value),
        .last_bit   (last_bit),
        .push       (push),
        .full       (full),
        .run_length (run_length),
        .run_bit    (run_bit),
        .token_last (token_last),
        .overflow   (overflow),
        .total_bits (total_bits),
        .empty      (empty),
        .pop        (pop),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One line per mismatch, with the printing capped.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= 100)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic result_t make_result(input int len, input logic b,
                                            input logic fin, input logic ovf,
                                            input int total);
        result_t r;
        r.run_length = len[CNT_W-1:0];
        r.run_bit    = b;
        r.token_last = fin;
        r.overflow   = ovf;
        r.total_bits = total[POS_W-1:0];
        return r;
    endfunction

    task automatic clear_stream();
        trk_bit        = 1'b0;
        trk_count      = 0;
        out_bits       = 0;
        fresh_stream   = 1'b1;
        stream_dropped = 1'b0;
    endtask

    // Queues one run token, or the overflow result when the budget is spent.
    task automatic emit_run_token(input bit is_final, output bit ok);
        if (out_bits + int'(TOKEN_BITS) > budget_limit)
        begin
            pending_tokens.push_back(make_result(0, 1'b0, 1'b1, 1'b1, 0));
            stream_dropped = 1'b1;
            ok = 1'b0;
        end
        else
        begin
            out_bits += int'(TOKEN_BITS);
            pending_tokens.push_back(make_result(trk_count, trk_bit, is_final, 1'b0,
                                                 is_final ? out_bits : 0));
            ok = 1'b1;
        end
    endtask

    // Works out the results that one accepted bit causes.
    task automatic encode_bit(input logic bv, input logic lb);
        bit ok;
        ok = 1'b1;
        if (stream_dropped)
        begin
            if (lb)
                clear_stream();
        end
        else
        begin
            if (fresh_stream)
            begin
                trk_bit      = bv;
                trk_count    = 1;
                fresh_stream = 1'b0;
            end
            else if (bv == trk_bit)
            begin
                // A full run is flushed before the new equal bit is counted.
                if (trk_count >= int'(RUN_CAP))
                begin
                    emit_run_token(1'b0, ok);
                    trk_count = 0;
                end
                trk_count++;
            end
            else
            begin
                emit_run_token(1'b0, ok);
                trk_count = 1;
                trk_bit   = bv;
            end
            if (ok && lb)
                emit_run_token(1'b1, ok);
            if (lb)
                clear_stream();
        end
    endtask

    // Presents one bit and holds it until the request is taken.
    task automatic send_bit(input logic bv, input logic lb);
        @(negedge clk);
        while ($urandom_range(99, 0) < send_idle)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        bit_value <= bv;
        last_bit  <= lb;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bits_sent++;
    endtask

    // Writes the budget once every expected result is out and the block is quiet.
    task automatic write_budget(input logic [POS_W-1:0] value);
        @(negedge clk);
        push <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        budget_limit = int'(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One complete stream: alternating runs, a scrambled stream now and then,
    // or a single long run when long_len is given.
    task automatic send_stream(input int long_len);
        int   runs;
        int   len;
        bit   noisy;
        logic bv;
        logic next_bit;
        logic is_last;
        bv    = 1'($urandom_range(1, 0));
        noisy = (long_len == 0) && ($urandom_range(3, 0) == 0);
        runs  = (long_len > 0) ? 1 : $urandom_range(6, 1);
        for (int r = 0; r < runs; r++)
        begin
            len = (long_len > 0) ? long_len : $urandom_range(5, 1);
            for (int j = 0; j < len; j++)
            begin
                next_bit = noisy ? 1'($urandom_range(1, 0)) : bv;
                is_last  = (r == runs - 1) && (j == len - 1);
                send_bit(next_bit, is_last);
                encode_bit(next_bit, is_last);
            end
            bv = ~bv;
        end
    endtask

    task automatic add_budget(input logic [POS_W-1:0] value);
        stim_row_t row;
        row        = '0;
        row.kind   = ROW_BUDGET;
        row.budget = value;
        directed_rows.push_back(row);
    endtask

    task automatic add_bit(input logic bv, input logic lb);
        stim_row_t row;
        row      = '0;
        row.kind = ROW_PREDICTED;
        row.bv   = bv;
        row.lb   = lb;
        directed_rows.push_back(row);
    endtask

    task automatic add_typed(input logic bv, input logic lb, input int n,
                             input result_t r0, input result_t r1);
        stim_row_t row;
        row         = '0;
        row.kind    = ROW_TYPED;
        row.bv      = bv;
        row.lb      = lb;
        row.n_typed = n[1:0];
        row.r0      = r0;
        row.r1      = r1;
        directed_rows.push_back(row);
    endtask

    // Compares one popped result with the oldest expectation.
    task automatic check_result();
        result_t want;
        if (pending_tokens.size() == 0)
        begin
            report_mismatch("result with nothing expected", 32'(run_length), 32'd0);
        end
        else
        begin
            want = pending_tokens.pop_front();
            if (run_length !== want.run_length)
                report_mismatch("run_length", 32'(run_length), 32'(want.run_length));
            if (run_bit !== want.run_bit)
                report_mismatch("run_bit", 32'(run_bit), 32'(want.run_bit));
            if (token_last !== want.token_last)
                report_mismatch("token_last", 32'(token_last), 32'(want.token_last));
            if (overflow !== want.overflow)
                report_mismatch("overflow", 32'(overflow), 32'(want.overflow));
            if (total_bits !== want.total_bits)
                report_mismatch("total_bits", 32'(total_bits), 32'(want.total_bits));
        end
    endtask

    // Result side: random pops, each taken result checked at the edge.
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            pop <= ($urandom_range(99, 0) >= recv_idle);
            @(posedge clk);
            if (pop && !empty)
                check_result();
        end
    end

    // Hang guard.
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stimulus and end of run.
    initial
    begin
        result_t   ovf_res;
        stim_row_t row;
        int        n0;
        int        start_bits;
        int        wait_cycles;
        logic [POS_W-1:0] next_budget;

        rst_n     = 1'b0;
        push      = 1'b0;
        bit_value = 1'b0;
        last_bit  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        err_count = 0;
        bits_sent = 0;
        send_idle = 26;
        recv_idle = 66;
        budget_limit = int'(BUDGET_RESET);
        clear_stream();

        // Directed table: single-bit streams, a changed run closed by the
        // final bit, overflow at once, overflow mid-stream with the rest of
        // the stream ignored, and a budget that fits exactly one token.
        ovf_res = make_result(0, 1'b0, 1'b1, 1'b1, 0);
        add_budget(16'hFFFF);
        add_typed(1'b0, 1'b1, 1, make_result(1, 1'b0, 1'b1, 1'b0, 9), '0);
        add_typed(1'b1, 1'b1, 1, make_result(1, 1'b1, 1'b1, 1'b0, 9), '0);
        add_bit(1'b0, 1'b0);
        add_bit(1'b0, 1'b0);
        add_typed(1'b1, 1'b1, 2, make_result(2, 1'b0, 1'b0, 1'b0, 0),
                  make_result(1, 1'b1, 1'b1, 1'b0, 18));
        add_bit(1'b1, 1'b0);
        add_bit(1'b0, 1'b0);
        add_bit(1'b1, 1'b0);
        add_bit(1'b1, 1'b1);
        add_budget(16'h0000);
        add_typed(1'b1, 1'b1, 1, ovf_res, '0);
        add_bit(1'b0, 1'b0);
        add_typed(1'b1, 1'b0, 1, ovf_res, '0);
        add_typed(1'b1, 1'b0, 0, '0, '0);
        add_typed(1'b0, 1'b1, 0, '0, '0);
        add_budget(16'd9);
        add_bit(1'b0, 1'b0);
        add_typed(1'b1, 1'b1, 2, make_result(1, 1'b0, 1'b0, 1'b0, 0), ovf_res);
        add_typed(1'b1, 1'b1, 1, make_result(1, 1'b1, 1'b1, 1'b0, 9), '0);
        add_budget(16'd8);
        add_typed(1'b0, 1'b1, 1, ovf_res, '0);
        add_budget(16'd18);
        add_bit(1'b0, 1'b0);
        add_bit(1'b1, 1'b0);
        add_bit(1'b0, 1'b1);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < directed_rows.size(); i++)
        begin
            row = directed_rows[i];
            if (row.kind == ROW_BUDGET)
            begin
                write_budget(row.budget);
            end
            else
            begin
                send_bit(row.bv, row.lb);
                // The tracked state always advances; typed rows replace what
                // it queued with the hand-written results.
                n0 = pending_tokens.size();
                encode_bit(row.bv, row.lb);
                if (row.kind == ROW_TYPED)
                begin
                    while (pending_tokens.size() > n0)
                        void'(pending_tokens.pop_back());
                    if (row.n_typed > 0)
                        pending_tokens.push_back(row.r0);
                    if (row.n_typed > 1)
                        pending_tokens.push_back(row.r1);
                end
            end
        end

        // Random streams: three idle patterns, two budgets each.
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle = (mode == 0) ? 26 : (mode == 1) ? 66 : 0;
            recv_idle = (mode == 0) ? 66 : (mode == 1) ? 26 : 0;
            for (int ph = 0; ph < 2; ph++)
            begin
                if (mode == 0)
                    next_budget = (ph == 0) ? 16'hFFFF : 16'($urandom_range(72, 0));
                else if (mode == 1)
                    next_budget = (ph == 0) ? 16'($urandom_range(72, 0))
                                            : 16'($urandom_range(65535, 0));
                else
                    next_budget = (ph == 0) ? 16'hFFFF : 16'($urandom_range(45, 9));
                write_budget(next_budget);
                // A run past the cap, closed by the final bit.
                if (mode == 2 && ph == 0)
                    send_stream(LONG_RUN);
                start_bits = bits_sent;
                while (bits_sent - start_bits < PHASE_BITS)
                    send_stream(0);
            end
        end

        // Drain and settle.
        @(negedge clk);
        push <= 1'b0;
        wait_cycles = 0;
        while (pending_tokens.size() != 0 && wait_cycles < 10000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (pending_tokens.size() != 0)
            report_mismatch("results never delivered", 32'd0,
                            32'(pending_tokens.size()));
        repeat (DRAIN_CYCLES * 4) @(posedge clk);

        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
